// File: design/gn3d_pkg.sv
// ----------------------------------------------------------------------------
// gn3d_pkg: shared types and constants for the 3D gradient noise block
// Table geometry, fixed-point formats, item modes and the gradient entry.
// ----------------------------------------------------------------------------
`default_nettype none

package gn3d_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int IDX_W           = $clog2(TABLE_SIZE);
    localparam int PERM_W          = 8;
    localparam int COORD_W         = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int GRAD_W          = 16;
    localparam int WEIGHT_W        = 16;
    localparam int OUT_W           = 16;

    // blend arithmetic widths
    localparam int LERP_W = 40;
    localparam int LO_W   = 20;
    localparam int PL_W   = WEIGHT_W + LO_W;
    localparam int PH_W   = WEIGHT_W + 1 + LERP_W - LO_W;
    localparam int FULL_W = PH_W + LO_W;

    typedef enum logic [1:0] {
        MODE_EVAL = 2'd0,
        MODE_PERM = 2'd1,
        MODE_GRAD = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gz;
    } grad_t;

    localparam int GRAD_ENTRY_W = $bits(grad_t);

endpackage

`default_nettype wire

// File: design/gradient_noise_3d.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d: pipelined 3D gradient noise evaluator
// Hashes lattice corners, dots gradients with offsets, blends with s-curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item.
//   mode selects: evaluate a point (coord_x/y/z, signed Q16.16), load a
//   permutation entry (table_index, perm_value) or load a gradient entry
//   (table_index, grad_x/y/z in Q1.14). Mode 3 passes through silently.
//   Output channel (out_valid / out_stall) carries one noise_value (Q1.14,
//   saturated) per evaluate transaction, in order; loads give nothing.
//   Throughput: one transaction per cycle while the receiver does not stall.
//   From acceptance to out_valid an item passes the capture stage, the two
//   permutation lookups, the gradient lookup, the dot-product stages, three
//   lerp levels of two stages each and the output register.
//   Loads travel down the pipe and write each table copy at the stage that
//   reads it, so evaluates see exactly the loads accepted before them.
//   Tables are undefined after reset; load every entry before evaluating.
//   Reset clears all valid bits; no clearing pass is needed.
//   When the receiver stalls a waiting result, the whole pipe holds and
//   in_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_3d
    import gn3d_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 mode,
    input  wire logic signed [COORD_W-1:0]  coord_x,
    input  wire logic signed [COORD_W-1:0]  coord_y,
    input  wire logic signed [COORD_W-1:0]  coord_z,
    input  wire logic [IDX_W-1:0]           table_index,
    input  wire logic [PERM_W-1:0]          perm_value,
    input  wire logic signed [GRAD_W-1:0]   grad_x,
    input  wire logic signed [GRAD_W-1:0]   grad_y,
    input  wire logic signed [GRAD_W-1:0]   grad_z,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [OUT_W-1:0]        noise_value
);

    localparam logic [17:0] THREE_ONE = 18'(3 * (1 << COORD_FRAC_BITS));
    localparam logic signed [LERP_W-1:0] SAT_HI = LERP_W'(32767);
    localparam logic signed [LERP_W-1:0] SAT_LO = -LERP_W'(32768);

    // lerp helpers: w * (b - a) split into a low unsigned and high signed part
    function automatic logic [PL_W-1:0] part_lo(input logic [WEIGHT_W-1:0] w,
                                                 input logic signed [LERP_W-1:0] a,
                                                 input logic signed [LERP_W-1:0] b);
        logic signed [LERP_W-1:0] d;
        d = b - a;
        return PL_W'(w) * PL_W'(d[LO_W-1:0]);
    endfunction

    function automatic logic signed [PH_W-1:0] part_hi(input logic [WEIGHT_W-1:0] w,
                                                       input logic signed [LERP_W-1:0] a,
                                                       input logic signed [LERP_W-1:0] b);
        logic signed [LERP_W-1:0] d;
        logic signed [PH_W-1:0]   ws;
        logic signed [PH_W-1:0]   ds;
        d  = b - a;
        ws = $signed(PH_W'({1'b0, w}));
        ds = PH_W'($signed(d[LERP_W-1:LO_W]));
        return ws * ds;
    endfunction

    function automatic logic signed [LERP_W-1:0] lerp_sum(input logic signed [LERP_W-1:0] a,
                                                         input logic signed [PH_W-1:0] ph,
                                                         input logic [PL_W-1:0] pl);
        logic signed [FULL_W-1:0] full;
        full = $signed({ph, {LO_W{1'b0}}}) + $signed({{(FULL_W-PL_W){1'b0}}, pl});
        return a + LERP_W'(full >>> WEIGHT_W);
    endfunction

    // global advance: hold everything while a result waits on a stalled receiver
    logic adv;
    logic out_valid_reg;
    logic signed [OUT_W-1:0] noise_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // ---------------- stage 1: capture ----------------
    logic                       s1_vld_reg;
    logic [1:0]                 s1_mode_reg;
    logic signed [COORD_W-1:0]  s1_coord_reg [3];
    logic [IDX_W-1:0]           s1_idx_reg;
    logic [PERM_W-1:0]          s1_perm_reg;
    grad_t                      s1_grad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mode_reg     <= mode;
            s1_coord_reg[0] <= coord_x;
            s1_coord_reg[1] <= coord_y;
            s1_coord_reg[2] <= coord_z;
            s1_idx_reg      <= table_index;
            s1_perm_reg     <= perm_value;
            s1_grad_reg     <= '{gx: grad_x, gy: grad_y, gz: grad_z};
        end
    end

    // split coordinates: floor cell (mod table) and fraction
    logic [IDX_W-1:0]            c1_cell [3];
    logic [COORD_FRAC_BITS-1:0]  c1_frac [3];
    logic [2*COORD_FRAC_BITS-1:0] c1_sq  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c1_cell[k] = s1_coord_reg[k][COORD_FRAC_BITS+IDX_W-1:COORD_FRAC_BITS];
            c1_frac[k] = s1_coord_reg[k][COORD_FRAC_BITS-1:0];
            c1_sq[k]   = (2*COORD_FRAC_BITS)'(c1_frac[k]) * (2*COORD_FRAC_BITS)'(c1_frac[k]);
        end
    end

    logic perm_a_we;
    logic [PERM_W-1:0] perm_i;
    logic [PERM_W-1:0] perm_j;

    assign perm_a_we = adv && s1_vld_reg && (s1_mode_reg == MODE_PERM);

    gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_a0 (
        .clk   (clk),
        .we    (perm_a_we),
        .waddr (s1_idx_reg),
        .wdata (s1_perm_reg),
        .re    (adv),
        .raddr (c1_cell[0]),
        .rdata (perm_i)
    );

    gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_a1 (
        .clk   (clk),
        .we    (perm_a_we),
        .waddr (s1_idx_reg),
        .wdata (s1_perm_reg),
        .re    (adv),
        .raddr (c1_cell[0] + IDX_W'(1)),
        .rdata (perm_j)
    );

    // ---------------- stage 2 ----------------
    logic                        s2_vld_reg;
    logic [1:0]                  s2_mode_reg;
    logic [IDX_W-1:0]            s2_idx_reg;
    logic [PERM_W-1:0]           s2_perm_reg;
    grad_t                       s2_grad_reg;
    logic [COORD_FRAC_BITS-1:0]  s2_frac_reg [3];
    logic [COORD_FRAC_BITS-1:0]  s2_sqhi_reg [3];
    logic [IDX_W-1:0]            s2_cy0_reg;
    logic [IDX_W-1:0]            s2_cz0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_perm_reg <= s1_perm_reg;
            s2_grad_reg <= s1_grad_reg;
            s2_cy0_reg  <= c1_cell[1];
            s2_cz0_reg  <= c1_cell[2];
            for (int k = 0; k < 3; k++)
            begin
                s2_frac_reg[k] <= c1_frac[k];
                s2_sqhi_reg[k] <= c1_sq[k][2*COORD_FRAC_BITS-1:COORD_FRAC_BITS];
            end
        end
    end

    // s-curve weight: t^2 * (3 - 2t)
    logic [COORD_FRAC_BITS-1:0] c2_w [3];
    logic [33:0]                c2_wprod [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c2_wprod[k] = 34'(s2_sqhi_reg[k]) *
                          34'(THREE_ONE - {1'b0, s2_frac_reg[k], 1'b0});
            c2_w[k]     = c2_wprod[k][2*COORD_FRAC_BITS-1:COORD_FRAC_BITS];
        end
    end

    logic perm_b_we;
    logic [IDX_W-1:0]  c2_cy1;
    logic [PERM_W-1:0] hash [4];

    assign perm_b_we = adv && s2_vld_reg && (s2_mode_reg == MODE_PERM);
    assign c2_cy1    = s2_cy0_reg + IDX_W'(1);

    // hash order: b00, b10, b01, b11 (x select in bit 0, y select in bit 1)
    for (genvar m = 0; m < 4; m++)
    begin : g_perm_b
        logic [IDX_W-1:0] addr;
        assign addr = ((m % 2 == 1) ? perm_j : perm_i) +
                      ((m / 2 == 1) ? c2_cy1 : s2_cy0_reg);

        gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_b (
            .clk   (clk),
            .we    (perm_b_we),
            .waddr (s2_idx_reg),
            .wdata (s2_perm_reg),
            .re    (adv),
            .raddr (addr),
            .rdata (hash[m])
        );
    end

    // ---------------- stage 3 ----------------
    logic                        s3_vld_reg;
    logic [1:0]                  s3_mode_reg;
    logic [IDX_W-1:0]            s3_idx_reg;
    grad_t                       s3_grad_reg;
    logic [COORD_FRAC_BITS-1:0]  s3_frac_reg [3];
    logic [2:0][WEIGHT_W-1:0]    s3_w_reg;
    logic [IDX_W-1:0]            s3_cz0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_grad_reg <= s2_grad_reg;
            s3_cz0_reg  <= s2_cz0_reg;
            for (int k = 0; k < 3; k++)
            begin
                s3_frac_reg[k] <= s2_frac_reg[k];
                s3_w_reg[k]    <= c2_w[k];
            end
        end
    end

    logic grad_we;
    logic [IDX_W-1:0]        c3_cz1;
    logic [GRAD_ENTRY_W-1:0] grad_raw [8];

    assign grad_we = adv && s3_vld_reg && (s3_mode_reg == MODE_GRAD);
    assign c3_cz1  = s3_cz0_reg + IDX_W'(1);

    // corner n: bit 0 selects x offset, bit 1 y, bit 2 z
    for (genvar n = 0; n < 8; n++)
    begin : g_grad
        logic [IDX_W-1:0] addr;
        assign addr = hash[n % 4] + ((n / 4 == 1) ? c3_cz1 : s3_cz0_reg);

        gn3d_ram #(.WIDTH(GRAD_ENTRY_W), .DEPTH(TABLE_SIZE)) u_grad (
            .clk   (clk),
            .we    (grad_we),
            .waddr (s3_idx_reg),
            .wdata (s3_grad_reg),
            .re    (adv),
            .raddr (addr),
            .rdata (grad_raw[n])
        );
    end

    // ---------------- stage 4: gradients ready; evaluates only from here ----
    logic                        s4_vld_reg;
    logic [COORD_FRAC_BITS-1:0]  s4_frac_reg [3];
    logic [2:0][WEIGHT_W-1:0]    s4_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg <= s3_vld_reg && (s3_mode_reg == MODE_EVAL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_w_reg <= s3_w_reg;
            for (int k = 0; k < 3; k++)
            begin
                s4_frac_reg[k] <= s3_frac_reg[k];
            end
        end
    end

    // offset products: r0 = frac, r1 = frac - 1 (same low bits, sign set)
    logic signed [32:0] c4_prod [8][3];

    always_comb
    begin
        grad_t g;
        logic signed [COORD_FRAC_BITS:0] r [3];
        for (int n = 0; n < 8; n++)
        begin
            g = grad_t'(grad_raw[n]);
            for (int k = 0; k < 3; k++)
            begin
                r[k] = $signed({n[k], s4_frac_reg[k]});
            end
            c4_prod[n][0] = g.gx * r[0];
            c4_prod[n][1] = g.gy * r[1];
            c4_prod[n][2] = g.gz * r[2];
        end
    end

    // ---------------- stage 5: products ----------------
    logic                     s5_vld_reg;
    logic signed [32:0]       s5_prod_reg [8][3];
    logic [2:0][WEIGHT_W-1:0] s5_w_reg;

    // ---------------- stage 6: dot products ----------------
    logic                     s6_vld_reg;
    logic signed [LERP_W-1:0] s6_dot_reg [8];
    logic [2:0][WEIGHT_W-1:0] s6_w_reg;

    // ---------------- stages 7..12: three lerp levels ----------------
    logic                     s7_vld_reg;
    logic [PL_W-1:0]          s7_pl_reg [4];
    logic signed [PH_W-1:0]   s7_ph_reg [4];
    logic signed [LERP_W-1:0] s7_a_reg  [4];
    logic [2:0][WEIGHT_W-1:0] s7_w_reg;

    logic                     s8_vld_reg;
    logic signed [LERP_W-1:0] s8_mix_reg [4];
    logic [2:0][WEIGHT_W-1:0] s8_w_reg;

    logic                     s9_vld_reg;
    logic [PL_W-1:0]          s9_pl_reg [2];
    logic signed [PH_W-1:0]   s9_ph_reg [2];
    logic signed [LERP_W-1:0] s9_a_reg  [2];
    logic [2:0][WEIGHT_W-1:0] s9_w_reg;

    logic                     s10_vld_reg;
    logic signed [LERP_W-1:0] s10_mix_reg [2];
    logic [WEIGHT_W-1:0]      s10_w_reg;

    logic                     s11_vld_reg;
    logic [PL_W-1:0]          s11_pl_reg;
    logic signed [PH_W-1:0]   s11_ph_reg;
    logic signed [LERP_W-1:0] s11_a_reg;

    logic                     s12_vld_reg;
    logic signed [LERP_W-1:0] s12_mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            s8_vld_reg    <= 1'b0;
            s9_vld_reg    <= 1'b0;
            s10_vld_reg   <= 1'b0;
            s11_vld_reg   <= 1'b0;
            s12_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            s8_vld_reg    <= s7_vld_reg;
            s9_vld_reg    <= s8_vld_reg;
            s10_vld_reg   <= s9_vld_reg;
            s11_vld_reg   <= s10_vld_reg;
            s12_vld_reg   <= s11_vld_reg;
            out_valid_reg <= s12_vld_reg;
        end
    end

    // final scale back to Q1.14 and clamp
    logic signed [LERP_W-1:0] c12_shift;
    logic signed [OUT_W-1:0]  c12_sat;

    always_comb
    begin
        c12_shift = s12_mix_reg >>> COORD_FRAC_BITS;
        if (c12_shift > SAT_HI)
        begin
            c12_sat = OUT_W'(SAT_HI);
        end
        else if (c12_shift < SAT_LO)
        begin
            c12_sat = OUT_W'(SAT_LO);
        end
        else
        begin
            c12_sat = c12_shift[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 5
            s5_w_reg <= s4_w_reg;
            for (int n = 0; n < 8; n++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s5_prod_reg[n][k] <= c4_prod[n][k];
                end
            end
            // stage 6
            s6_w_reg <= s5_w_reg;
            for (int n = 0; n < 8; n++)
            begin
                s6_dot_reg[n] <= LERP_W'(s5_prod_reg[n][0]) + LERP_W'(s5_prod_reg[n][1])
                               + LERP_W'(s5_prod_reg[n][2]);
            end
            // level 1 along x
            s7_w_reg <= s6_w_reg;
            for (int m = 0; m < 4; m++)
            begin
                s7_pl_reg[m] <= part_lo(s6_w_reg[0], s6_dot_reg[2*m], s6_dot_reg[2*m+1]);
                s7_ph_reg[m] <= part_hi(s6_w_reg[0], s6_dot_reg[2*m], s6_dot_reg[2*m+1]);
                s7_a_reg[m]  <= s6_dot_reg[2*m];
            end
            s8_w_reg <= s7_w_reg;
            for (int m = 0; m < 4; m++)
            begin
                s8_mix_reg[m] <= lerp_sum(s7_a_reg[m], s7_ph_reg[m], s7_pl_reg[m]);
            end
            // level 2 along y
            s9_w_reg <= s8_w_reg;
            for (int m = 0; m < 2; m++)
            begin
                s9_pl_reg[m] <= part_lo(s8_w_reg[1], s8_mix_reg[2*m], s8_mix_reg[2*m+1]);
                s9_ph_reg[m] <= part_hi(s8_w_reg[1], s8_mix_reg[2*m], s8_mix_reg[2*m+1]);
                s9_a_reg[m]  <= s8_mix_reg[2*m];
            end
            s10_w_reg <= s9_w_reg[2];
            for (int m = 0; m < 2; m++)
            begin
                s10_mix_reg[m] <= lerp_sum(s9_a_reg[m], s9_ph_reg[m], s9_pl_reg[m]);
            end
            // level 3 along z
            s11_pl_reg  <= part_lo(s10_w_reg, s10_mix_reg[0], s10_mix_reg[1]);
            s11_ph_reg  <= part_hi(s10_w_reg, s10_mix_reg[0], s10_mix_reg[1]);
            s11_a_reg   <= s10_mix_reg[0];
            s12_mix_reg <= lerp_sum(s11_a_reg, s11_ph_reg, s11_pl_reg);
            // output register
            noise_reg   <= c12_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

    // hold the whole pipe while a result waits on a stalled receiver
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(s12_vld_reg) && $stable(s4_vld_reg)
                                      && $stable(s1_vld_reg)))
        else $error("pipeline moved while output stalled");

    // a new result only comes from a valid last blend stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s12_vld_reg))
        else $error("result without a blended item behind it");

endmodule

`default_nettype wire

// File: design/gn3d_ram.sv
// ----------------------------------------------------------------------------
// gn3d_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gn3d_ram
    import gn3d_pkg::*;
#(
    parameter int WIDTH = PERM_W,
    parameter int DEPTH = TABLE_SIZE
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: tb/gradient_noise_3d_tb.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d_tb: self-checking testbench for the 3D gradient noise block
// Fills both tables, then runs directed and random evaluate, load and unused
// transactions with random gaps and stalls on both channels. A predictor
// computes each expected noise value and a monitor checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_3d_tb;
    import gn3d_pkg::*;

    typedef struct {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [IDX_W-1:0]          idx;
        logic [PERM_W-1:0]         pv;
        logic signed [GRAD_W-1:0]  gx;
        logic signed [GRAD_W-1:0]  gy;
        logic signed [GRAD_W-1:0]  gz;
    } noise_item_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                mode = MODE_EVAL;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic signed [COORD_W-1:0] coord_z = '0;
    logic [IDX_W-1:0]          table_index = '0;
    logic [PERM_W-1:0]         perm_value = '0;
    logic signed [GRAD_W-1:0]  grad_x = '0;
    logic signed [GRAD_W-1:0]  grad_y = '0;
    logic signed [GRAD_W-1:0]  grad_z = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [OUT_W-1:0]   noise_value;

    // Shadow copies of the block's tables
    logic [PERM_W-1:0]        perm_shadow [TABLE_SIZE];
    logic signed [GRAD_W-1:0] grad_shadow [TABLE_SIZE][3];

    noise_item_t               pending_items[$];
    logic signed [OUT_W-1:0]   expected_noise[$];
    noise_item_t               cur_item;

    int  sent_count = 0;
    int  result_count = 0;
    int  idle_cycles = 0;
    bit  failed = 1'b0;
    bit  stimulus_done = 1'b0;

    gradient_noise_3d u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .table_index (table_index),
        .perm_value  (perm_value),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------------
    // s-curve 3t^2 - 2t^3 on a Q0.16 fraction, result in 16 fraction bits
    function automatic longint s_curve(longint t);
        longint t2;
        begin
            t2 = (t * t) >>> COORD_FRAC_BITS;
            return (t2 * (3 * (64'sd1 <<< COORD_FRAC_BITS) - 2 * t)) >>> COORD_FRAC_BITS;
        end
    endfunction

    // Arithmetic shift gives floor division for negative products
    function automatic longint lerp16(longint w, longint a, longint b);
        begin
            return a + ((w * (b - a)) >>> 16);
        end
    endfunction

    function automatic longint grad_dot(logic [IDX_W-1:0] gi, longint rx, longint ry,
                                        longint rz);
        begin
            return longint'(grad_shadow[gi][0]) * rx + longint'(grad_shadow[gi][1]) * ry
                 + longint'(grad_shadow[gi][2]) * rz;
        end
    endfunction

    // Apply one transaction to the shadow tables; return 1 with the noise
    // value when the transaction produces a result.
    function automatic bit predict_noise(noise_item_t it, output logic signed [OUT_W-1:0] nv);
        logic [IDX_W-1:0] c0 [3];
        logic [IDX_W-1:0] c1 [3];
        longint           r0 [3];
        longint           r1 [3];
        longint           w [3];
        logic [IDX_W-1:0] pi, pj, b00, b10, b01, b11;
        longint           u, v, a, b, c, d, res;
        logic signed [COORD_W-1:0] cv;
        begin
            nv = '0;
            if (it.mode == MODE_PERM) begin
                perm_shadow[it.idx] = it.pv;
                return 1'b0;
            end
            if (it.mode == MODE_GRAD) begin
                grad_shadow[it.idx][0] = it.gx;
                grad_shadow[it.idx][1] = it.gy;
                grad_shadow[it.idx][2] = it.gz;
                return 1'b0;
            end
            if (it.mode != MODE_EVAL)
                return 1'b0;
            for (int k = 0; k < 3; k++) begin
                cv = (k == 0) ? it.cx : (k == 1) ? it.cy : it.cz;
                // floor of the coordinate keeps the cell; wrap to the table size
                c0[k] = cv[COORD_FRAC_BITS +: IDX_W];
                c1[k] = c0[k] + IDX_W'(1);
                r0[k] = longint'(cv[COORD_FRAC_BITS-1:0]);
                r1[k] = r0[k] - (64'sd1 <<< COORD_FRAC_BITS);
                w[k]  = s_curve(r0[k]);
            end
            pi  = perm_shadow[c0[0]];
            pj  = perm_shadow[c1[0]];
            b00 = perm_shadow[IDX_W'(pi + c0[1])];
            b10 = perm_shadow[IDX_W'(pj + c0[1])];
            b01 = perm_shadow[IDX_W'(pi + c1[1])];
            b11 = perm_shadow[IDX_W'(pj + c1[1])];

            u = grad_dot(IDX_W'(b00 + c0[2]), r0[0], r0[1], r0[2]);
            v = grad_dot(IDX_W'(b10 + c0[2]), r1[0], r0[1], r0[2]);
            a = lerp16(w[0], u, v);
            u = grad_dot(IDX_W'(b01 + c0[2]), r0[0], r1[1], r0[2]);
            v = grad_dot(IDX_W'(b11 + c0[2]), r1[0], r1[1], r0[2]);
            b = lerp16(w[0], u, v);
            c = lerp16(w[1], a, b);

            u = grad_dot(IDX_W'(b00 + c1[2]), r0[0], r0[1], r1[2]);
            v = grad_dot(IDX_W'(b10 + c1[2]), r1[0], r0[1], r1[2]);
            a = lerp16(w[0], u, v);
            u = grad_dot(IDX_W'(b01 + c1[2]), r0[0], r1[1], r1[2]);
            v = grad_dot(IDX_W'(b11 + c1[2]), r1[0], r1[1], r1[2]);
            b = lerp16(w[0], u, v);
            d = lerp16(w[1], a, b);

            res = lerp16(w[2], c, d) >>> COORD_FRAC_BITS;
            // saturate to the output range
            if (res > 32767)
                res = 32767;
            if (res < -32768)
                res = -32768;
            nv = OUT_W'(res);
            return 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    function automatic noise_item_t rand_item(logic [1:0] m);
        noise_item_t it;
        begin
            it.mode = m;
            it.cx   = $urandom;
            it.cy   = $urandom;
            it.cz   = $urandom;
            it.idx  = IDX_W'($urandom);
            it.pv   = PERM_W'($urandom);
            it.gx   = GRAD_W'($urandom_range(32768) - 16384);
            it.gy   = GRAD_W'($urandom_range(32768) - 16384);
            it.gz   = GRAD_W'($urandom_range(32768) - 16384);
            return it;
        end
    endfunction

    function automatic noise_item_t eval_item(logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [31:0] z);
        noise_item_t it;
        begin
            it    = rand_item(MODE_EVAL);
            it.cx = x;
            it.cy = y;
            it.cz = z;
            return it;
        end
    endfunction

    // Coordinates near the origin most of the time, full range otherwise
    function automatic logic signed [31:0] rand_coord();
        begin
            if ($urandom_range(3) == 0)
                return $urandom;
            return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        end
    endfunction

    initial begin
        noise_item_t it;
        int          roll;

        // Fill every table entry before any evaluate; extremes of the
        // gradient range land on the first and last entries.
        for (int i = 0; i < TABLE_SIZE; i++) begin
            it     = rand_item(MODE_PERM);
            it.idx = IDX_W'(i);
            it.pv  = (i == 0) ? 8'hff : (i == 1) ? 8'h00 : 8'($urandom);
            pending_items.push_back(it);
            it     = rand_item(MODE_GRAD);
            it.idx = IDX_W'(i);
            if (i == 0) begin
                it.gx = GRAD_W'(16384);
                it.gy = GRAD_W'(16384);
                it.gz = GRAD_W'(16384);
            end else if (i == TABLE_SIZE - 1) begin
                it.gx = GRAD_W'(-16384);
                it.gy = GRAD_W'(-16384);
                it.gz = GRAD_W'(-16384);
            end
            pending_items.push_back(it);
        end

        // Directed evaluates: lattice points, coordinate extremes, negative
        // cells, fractions just below one, and cell wrap past the table end.
        pending_items.push_back(eval_item(0, 0, 0));
        pending_items.push_back(eval_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        pending_items.push_back(eval_item(32'sh80000000, 32'sh80000000, 32'sh80000000));
        pending_items.push_back(eval_item(-1, -1, -1));
        pending_items.push_back(eval_item(32'sh0000ffff, 32'sh0000ffff, 32'sh0000ffff));
        pending_items.push_back(eval_item(32'sh00ff8000, 32'sh00ff8000, 32'sh00ff8000));
        pending_items.push_back(eval_item(32'sh00008000, 32'sh00008000, 32'sh00008000));
        pending_items.push_back(eval_item(32'shffff8000, 32'sh00010000, 32'shff000001));
        pending_items.push_back(eval_item(32'sh12340001, 32'shedcb0000, 32'sh00ffffff));
        pending_items.push_back(eval_item(32'shf0000000, 32'sh0fff7fff, 32'sh80008000));
        // Unused mode: no result, no table change
        pending_items.push_back(rand_item(2'd3));
        pending_items.push_back(eval_item(32'sh00ff8000, 32'sh00ff8000, 32'sh00ff8000));
        // Load at the table ends, then read them back through an evaluate
        it     = rand_item(MODE_PERM);
        it.idx = 8'hff;
        it.pv  = 8'hff;
        pending_items.push_back(it);
        it     = rand_item(MODE_GRAD);
        it.idx = 8'h00;
        it.gx  = GRAD_W'(16384);
        it.gy  = GRAD_W'(-16384);
        it.gz  = GRAD_W'(16384);
        pending_items.push_back(it);
        pending_items.push_back(eval_item(32'sh00ffc000, 32'sh00ff4000, 32'sh00ff0001));
        pending_items.push_back(eval_item(32'shffff0000, 32'shffffffff, 32'sh0));

        // Random mix: mostly evaluates, with loads and unused transactions
        for (int n = 0; n < 870; n++) begin
            roll = $urandom_range(99);
            if (roll < 72)
                it = eval_item(rand_coord(), rand_coord(), rand_coord());
            else if (roll < 82)
                it = rand_item(MODE_PERM);
            else if (roll < 92)
                it = rand_item(MODE_GRAD);
            else
                it = rand_item(2'd3);
            pending_items.push_back(it);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (stimulus_done && expected_noise.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && expected_noise.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: present one transaction at a time; hold it while stalled
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        noise_item_t              it;
        logic signed [OUT_W-1:0]  nv;
        bit                       quiet;
        if (rst_n) begin
            // Record the transaction accepted at this edge
            if (in_valid && !in_stall) begin
                sent_count <= sent_count + 1;
                if (predict_noise(cur_item, nv))
                    expected_noise.push_back(nv);
            end
            if (!in_valid || !in_stall) begin
                quiet = (sent_count >= 700 && sent_count < 1000);
                if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
                    it           = pending_items.pop_front();
                    cur_item     <= it;
                    in_valid     <= 1'b1;
                    mode         <= it.mode;
                    coord_x      <= it.cx;
                    coord_y      <= it.cy;
                    coord_z      <= it.cz;
                    table_index  <= it.idx;
                    perm_value   <= it.pv;
                    grad_x       <= it.gx;
                    grad_y       <= it.gy;
                    grad_z       <= it.gz;
                end else begin
                    in_valid <= 1'b0;
                    if (pending_items.size() == 0)
                        stimulus_done <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall at random, check each accepted result in order
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        logic signed [OUT_W-1:0] exp_nv;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                result_count <= result_count + 1;
                if (expected_noise.size() == 0) begin
                    $display("%0t: unexpected result noise_value=%0d", $realtime,
                             noise_value);
                    failed <= 1'b1;
                end else begin
                    exp_nv = expected_noise.pop_front();
                    if (noise_value !== exp_nv) begin
                        $display("%0t: noise_value mismatch expected=%0d actual=%0d",
                                 $realtime, exp_nv, noise_value);
                        failed <= 1'b1;
                    end
                end
            end
            // Drop the stall entirely in one stretch of results
            if (result_count >= 300 && result_count < 600)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 9);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

`default_nettype wire

// File: sim.f
design/gn3d_pkg.sv
design/gn3d_ram.sv
design/gradient_noise_3d.sv
tb/gradient_noise_3d_tb.sv
